// File: rtl/core/wsfb_pkg.sv
// shared constants, types and helpers for the websocket frame builder
package wsfb_pkg;

	// length coding limits of the frame header
	localparam int unsigned LEN_DIRECT_MAX = 125;
	localparam int unsigned LEN_16_LIMIT   = 65536;
	localparam logic [6:0]  LEN_CODE_16    = 7'd126;
	localparam logic [6:0]  LEN_CODE_64    = 7'd127;

	// header bytes: two fixed, up to eight extended length, four key
	localparam int unsigned HDR_BYTES    = 14;
	localparam int unsigned HDR_REST     = HDR_BYTES - 1;
	localparam int unsigned HDR_CNT_W    = $clog2(HDR_BYTES);
	localparam int unsigned EXT16_BYTES  = 2;
	localparam int unsigned EXT64_BYTES  = 8;
	localparam int unsigned KEY_BYTES    = 4;

	localparam int unsigned LEN_W = 31;
	localparam int unsigned CFG_W = 32;

	// request kinds
	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// configuration register indexes
	localparam logic CFG_MASK_ENABLE = 1'b0;
	localparam logic CFG_MASK_KEY    = 1'b1;

	typedef enum logic [1:0] {
		LEN_DIRECT,
		LEN_EXT16,
		LEN_EXT64
	} len_class_t;

	// formatted header: first byte goes straight out, the rest queue up
	typedef struct packed {
		logic [7:0]                    first;
		logic [HDR_REST-1:0][7:0]      rest;
		logic [HDR_CNT_W-1:0]          rest_cnt;
		logic                          empty;
	} hdr_t;

	// mask key byte for a payload index mod 4, most significant byte first
	function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] phase);
		logic [7:0] b;
		case (phase)
			2'd0:    b = key[31:24];
			2'd1:    b = key[23:16];
			2'd2:    b = key[15:8];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

endpackage

// File: rtl/core/wsfb_hdr_fmt.sv
// frame header formatter: fin/opcode, mask/length code, extended length, key
module wsfb_hdr_fmt (
	input  logic [30:0]    frame_len,
	input  logic [3:0]     opcode,
	input  logic           final_fragment,
	input  logic           mask_enable,
	input  logic [31:0]    mask_key,
	output wsfb_pkg::hdr_t hdr
);

	wsfb_pkg::len_class_t len_class;
	logic [6:0]           len_code;
	logic [7:0]           k0, k1, k2, k3;

	// length class and 7-bit code
	always_comb begin
		if (frame_len <= wsfb_pkg::LEN_W'(wsfb_pkg::LEN_DIRECT_MAX)) begin
			len_class = wsfb_pkg::LEN_DIRECT;
			len_code  = frame_len[6:0];
		end else if (frame_len < wsfb_pkg::LEN_W'(wsfb_pkg::LEN_16_LIMIT)) begin
			len_class = wsfb_pkg::LEN_EXT16;
			len_code  = wsfb_pkg::LEN_CODE_16;
		end else begin
			len_class = wsfb_pkg::LEN_EXT64;
			len_code  = wsfb_pkg::LEN_CODE_64;
		end
	end

	assign k0 = wsfb_pkg::key_byte(mask_key, 2'd0);
	assign k1 = wsfb_pkg::key_byte(mask_key, 2'd1);
	assign k2 = wsfb_pkg::key_byte(mask_key, 2'd2);
	assign k3 = wsfb_pkg::key_byte(mask_key, 2'd3);

	// byte layout after the first byte, key bytes only counted when masking
	always_comb begin
		hdr.first = {final_fragment, 3'b000, opcode};
		hdr.empty = (frame_len == '0);
		hdr.rest  = '0;
		hdr.rest[0] = {mask_enable, len_code};
		case (len_class)
			wsfb_pkg::LEN_EXT16: begin
				hdr.rest[1] = frame_len[15:8];
				hdr.rest[2] = frame_len[7:0];
				hdr.rest[3] = k0;
				hdr.rest[4] = k1;
				hdr.rest[5] = k2;
				hdr.rest[6] = k3;
				hdr.rest_cnt = wsfb_pkg::HDR_CNT_W'(1 + wsfb_pkg::EXT16_BYTES);
			end
			wsfb_pkg::LEN_EXT64: begin
				// upper four length bytes stay zero
				hdr.rest[5]  = {1'b0, frame_len[30:24]};
				hdr.rest[6]  = frame_len[23:16];
				hdr.rest[7]  = frame_len[15:8];
				hdr.rest[8]  = frame_len[7:0];
				hdr.rest[9]  = k0;
				hdr.rest[10] = k1;
				hdr.rest[11] = k2;
				hdr.rest[12] = k3;
				hdr.rest_cnt = wsfb_pkg::HDR_CNT_W'(1 + wsfb_pkg::EXT64_BYTES);
			end
			default: begin
				hdr.rest[1] = k0;
				hdr.rest[2] = k1;
				hdr.rest[3] = k2;
				hdr.rest[4] = k3;
				hdr.rest_cnt = wsfb_pkg::HDR_CNT_W'(1);
			end
		endcase
		if (mask_enable) begin
			hdr.rest_cnt = hdr.rest_cnt + wsfb_pkg::HDR_CNT_W'(wsfb_pkg::KEY_BYTES);
		end
	end

endmodule

// File: rtl/core/websocket_frame_builder.sv
// websocket frame builder top level: input stage, header queue, output register
// an accepted item moves from the input stage register into the output register when taken
// throughput, while out_stall is low: one payload byte per cycle; a start item holds the
// output for its header bytes, 2 to 14 (2 + extended length bytes + 4 key bytes if
// masking); the header queue is a 13-byte shift register drained one byte per cycle
// reset: asynchronous active-low; clears control registers, no frame open, output empty
module websocket_frame_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [30:0] frame_len,
	input  logic [3:0]  opcode,
	input  logic        final_fragment,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_last
);

	logic                                 mask_enable_q;
	logic [31:0]                          mask_key_q;

	logic                                 valid_s1;
	logic                                 req_type_s1;
	logic [30:0]                          frame_len_s1;
	logic [3:0]                           opcode_s1;
	logic                                 final_fragment_s1;
	logic [7:0]                           payload_byte_s1;

	logic [30:0]                          rem_q;
	logic [1:0]                           phase_q;
	logic [wsfb_pkg::HDR_REST-1:0][7:0]   hdr_q;
	logic [wsfb_pkg::HDR_CNT_W-1:0]       hdr_cnt_q;
	logic                                 hdr_empty_q;

	logic                                 out_valid_q;
	logic [7:0]                           out_byte_q;
	logic                                 out_last_q;

	wsfb_pkg::hdr_t                       hdr;
	logic                                 out_free;
	logic                                 hdr_busy;
	logic                                 frame_open;
	logic                                 take_s1;
	logic [7:0]                           masked_byte;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_enable_q <= 1'b0;
			mask_key_q    <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				wsfb_pkg::CFG_MASK_ENABLE: mask_enable_q <= cfg_data[0];
				wsfb_pkg::CFG_MASK_KEY:    mask_key_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	wsfb_hdr_fmt u_hdr_fmt (
		.frame_len      (frame_len_s1),
		.opcode         (opcode_s1),
		.final_fragment (final_fragment_s1),
		.mask_enable    (mask_enable_q),
		.mask_key       (mask_key_q),
		.hdr            (hdr)
	);

	// stage control
	assign out_free   = !out_valid_q || !out_stall;
	assign hdr_busy   = (hdr_cnt_q != '0);
	assign frame_open = (rem_q != '0);
	assign take_s1    = valid_s1 && !hdr_busy &&
		(out_free || (req_type_s1 == wsfb_pkg::REQ_PAYLOAD && !frame_open));
	assign in_stall   = valid_s1 && !take_s1;

	assign masked_byte = payload_byte_s1 ^
		(mask_enable_q ? wsfb_pkg::key_byte(mask_key_q, phase_q) : 8'h00);

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1       <= req_type;
			frame_len_s1      <= frame_len;
			opcode_s1         <= opcode;
			final_fragment_s1 <= final_fragment;
			payload_byte_s1   <= payload_byte;
		end
	end

	// frame state, header queue and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			phase_q     <= '0;
			hdr_cnt_q   <= '0;
			hdr_empty_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (hdr_busy) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
					hdr_cnt_q   <= hdr_cnt_q - 1'b1;
				end
			end else if (take_s1 && req_type_s1 == wsfb_pkg::REQ_START) begin
				out_valid_q <= 1'b1;
				hdr_cnt_q   <= hdr.rest_cnt;
				hdr_empty_q <= hdr.empty;
				rem_q       <= frame_len_s1;
				phase_q     <= '0;
			end else if (take_s1 && frame_open) begin
				out_valid_q <= 1'b1;
				rem_q       <= rem_q - 1'b1;
				phase_q     <= phase_q + 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header queue and output byte data
	always_ff @(posedge clk) begin
		if (hdr_busy) begin
			if (out_free) begin
				out_byte_q <= hdr_q[0];
				out_last_q <= hdr_empty_q && (hdr_cnt_q == wsfb_pkg::HDR_CNT_W'(1));
				hdr_q      <= {8'h00, hdr_q[wsfb_pkg::HDR_REST-1:1]};
			end
		end else if (take_s1) begin
			if (req_type_s1 == wsfb_pkg::REQ_START) begin
				out_byte_q <= hdr.first;
				out_last_q <= 1'b0;
				hdr_q      <= hdr.rest;
			end else if (frame_open) begin
				out_byte_q <= masked_byte;
				out_last_q <= (rem_q == 31'd1);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign frame_last = out_last_q;

	// a marked last byte means the frame is closed and no header is queued
	a_last_closes_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_last |-> (rem_q == '0) && !hdr_busy)
		else $error("last byte shown while frame still open");

	// frame state is frozen while a header burst drains
	a_state_held_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_busy |=> $stable(rem_q) && $stable(phase_q))
		else $error("frame state changed during header burst");

	// a header burst keeps the output stream filled
	a_burst_keeps_output: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_busy && out_free |=> out_valid)
		else $error("gap in header burst");

endmodule

// File: dv/tb_websocket_frame_builder.sv
// self-checking testbench for the websocket frame builder: directed table, random frames
`timescale 1ns / 1ps

module tb_websocket_frame_builder;

	localparam int RX_HOLD_CYCLES = 120;
	localparam int QUIET_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_REPORTS    = 10;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_ITEMS    = 34;

	// one byte of the serialised frame
	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} ws_byte_t;

	// directed row: either a register write or an input transfer
	typedef struct packed {
		bit          is_cfg;
		logic        cfg_idx;
		logic [31:0] cfg_val;
		logic        kind;
		logic [30:0] len;
		logic [3:0]  op;
		logic        fin;
		logic [7:0]  pb;
		bit          typed;
		int          tn;
		logic [111:0] th;
		bit          tl;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [30:0] frame_len;
	logic [3:0]  opcode;
	logic        final_fragment;
	logic [7:0]  payload_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        frame_last;

	// typed expectation travelling with the current transfer
	bit           cur_typed;
	int           cur_tn;
	logic [111:0] cur_th;
	bit           cur_tl;

	// predictor state and register copy
	logic [30:0] open_left = '0;
	logic [1:0]  key_phase = '0;
	logic        mask_on   = 1'b0;
	logic [31:0] key_reg   = '0;

	ws_byte_t frame_bytes_exp[$];
	ws_byte_t frame_bytes_new[$];
	dir_row_t dir_rows[$];

	int mismatch_cnt = 0;
	int checked_cnt  = 0;
	int start_cnt    = 0;
	int pay_cnt      = 0;
	int drop_cnt     = 0;
	int full_cnt     = 0;
	int idle_cnt     = 0;
	int burst_left   = 0;
	int hold_asks    = 0;
	int settings_cnt = 0;
	logic [30:0] gen_open = '0;

	websocket_frame_builder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.frame_len      (frame_len),
		.opcode         (opcode),
		.final_fragment (final_fragment),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.frame_last     (frame_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic ws_byte_t mk_byte(input logic [7:0] d, input logic l);
		ws_byte_t r;
		r.data    = d;
		r.is_last = l;
		return r;
	endfunction

	function automatic dir_row_t mk_row(input logic kind, input logic [30:0] len,
			input logic [3:0] op, input logic fin, input logic [7:0] pb, input bit typed,
			input int tn, input logic [111:0] th, input bit tl);
		dir_row_t r;
		r         = '0;
		r.kind    = kind;
		r.len     = len;
		r.op      = op;
		r.fin     = fin;
		r.pb      = pb;
		r.typed   = typed;
		r.tn      = tn;
		r.th      = th;
		r.tl      = tl;
		return r;
	endfunction

	function automatic dir_row_t mk_cfg(input logic idx, input logic [31:0] val);
		dir_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	// frame bytes caused by one accepted transfer, into frame_bytes_new
	task automatic predict_frame_bytes(input logic kind, input logic [30:0] len,
			input logic [3:0] op, input logic fin, input logic [7:0] pb);
		logic [6:0]  code;
		logic [63:0] len64;
		logic [7:0]  b;
		int          n_ext;
		int          hdr_n;
		int          idx;
		int          pos;
		int          i;
		len64 = {33'd0, len};
		if (kind == wsfb_pkg::REQ_START) begin
			start_cnt++;
			if (len <= wsfb_pkg::LEN_DIRECT_MAX) begin
				code  = len[6:0];
				n_ext = 0;
			end else if (len < wsfb_pkg::LEN_16_LIMIT) begin
				code  = wsfb_pkg::LEN_CODE_16;
				n_ext = wsfb_pkg::EXT16_BYTES;
			end else begin
				code  = wsfb_pkg::LEN_CODE_64;
				n_ext = wsfb_pkg::EXT64_BYTES;
			end
			hdr_n = 2 + n_ext + (mask_on ? wsfb_pkg::KEY_BYTES : 0);
			idx   = 0;
			frame_bytes_new.push_back(mk_byte({fin, 3'b000, op}, 1'b0));
			idx++;
			frame_bytes_new.push_back(mk_byte({mask_on, code},
				(len == 0) && (idx == hdr_n - 1)));
			idx++;
			// extended length, big-endian
			for (i = 0; i < n_ext; i++) begin
				pos = n_ext - 1 - i;
				frame_bytes_new.push_back(mk_byte(len64[8*pos +: 8],
					(len == 0) && (idx == hdr_n - 1)));
				idx++;
			end
			// key bytes, most significant first
			if (mask_on) begin
				for (i = 0; i < wsfb_pkg::KEY_BYTES; i++) begin
					frame_bytes_new.push_back(mk_byte(key_reg[8*(3-i) +: 8],
						(len == 0) && (idx == hdr_n - 1)));
					idx++;
				end
			end
			open_left = len;
			key_phase = 2'd0;
		end else if (open_left == 0) begin
			drop_cnt++;
		end else begin
			pay_cnt++;
			b = pb;
			if (mask_on)
				b = b ^ key_reg[8*(3-key_phase) +: 8];
			open_left = open_left - 1'b1;
			key_phase = key_phase + 1'b1;
			frame_bytes_new.push_back(mk_byte(b, open_left == 0));
		end
	endtask

	task automatic flag_mismatch(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_REPORTS)
			$display("mismatch: %s", msg);
	endtask

	// output check and prediction on each transfer
	always @(posedge clk) begin : frame_check
		ws_byte_t want;
		int       i;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				checked_cnt++;
				if (frame_bytes_exp.size() == 0) begin
					flag_mismatch($sformatf("exp no byte, got %02h frame_last %0b",
						out_byte, frame_last));
				end else begin
					want = frame_bytes_exp.pop_front();
					if (want.data !== out_byte || want.is_last !== frame_last)
						flag_mismatch($sformatf(
							"byte exp %02h got %02h, frame_last exp %0b got %0b",
							want.data, out_byte, want.is_last, frame_last));
				end
			end
			if (in_valid && !in_stall) begin
				predict_frame_bytes(req_type, frame_len, opcode, final_fragment,
					payload_byte);
				// rows with a written-out header replace the prediction
				if (cur_typed) begin
					frame_bytes_new.delete();
					for (i = 0; i < cur_tn; i++)
						frame_bytes_new.push_back(mk_byte(cur_th[8*(cur_tn-1-i) +: 8],
							cur_tl && (i == cur_tn - 1)));
				end
				while (frame_bytes_new.size() != 0)
					frame_bytes_exp.push_back(frame_bytes_new.pop_front());
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (in_valid && in_stall)
			full_cnt++;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cnt);
			$display("tb_websocket_frame_builder: done, errors");
			$finish;
		end
	end

	// receiver: stall segments of random density, plus long hold-offs on request
	initial begin : rx_stall_gen
		int seg_left;
		int pct;
		int hold_left;
		int hold_done;
		seg_left  = 0;
		pct       = 0;
		hold_left = 0;
		hold_done = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_done != hold_asks) begin
				hold_done++;
				hold_left = RX_HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 40);
					case ($urandom_range(0, 3))
						0:       pct = 0;
						1:       pct = 20;
						2:       pct = 50;
						default: pct = 85;
					endcase
				end
				seg_left--;
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// one input transfer, preceded by a gap when the burst runs out
	task automatic push_item(input logic kind, input logic [30:0] len, input logic [3:0] op,
			input logic fin, input logic [7:0] pb, input bit typed, input int tn,
			input logic [111:0] th, input bit tl);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		in_valid       <= 1'b1;
		req_type       <= kind;
		frame_len      <= len;
		opcode         <= op;
		final_fragment <= fin;
		payload_byte   <= pb;
		cur_typed      <= typed;
		cur_tn         <= tn;
		cur_th         <= th;
		cur_tl         <= tl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop offering, wait for every expected byte, then let the pipeline empty
	task automatic settle_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (frame_bytes_exp.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		settle_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == wsfb_pkg::CFG_MASK_ENABLE)
			mask_on = val[0];
		else
			key_reg = val;
	endtask

	// random start; other fields random too so every input bit toggles
	task automatic send_start(input logic [30:0] len);
		gen_open = len;
		push_item(wsfb_pkg::REQ_START, len, 4'($urandom), 1'($urandom), 8'($urandom),
			1'b0, 0, '0, 1'b0);
	endtask

	task automatic send_payload(output bit counted);
		counted = (gen_open != 0);
		if (counted)
			gen_open--;
		push_item(wsfb_pkg::REQ_PAYLOAD, 31'($urandom), 4'($urandom), 1'($urandom),
			8'($urandom), 1'b0, 0, '0, 1'b0);
	endtask

	// mostly whole short frames, then truncated and long-length frames, strays and empties
	task automatic run_random_phase(input int n_items);
		int          done_items;
		int          pick;
		int          n;
		int          k;
		bit          counted;
		logic [30:0] len;
		done_items = 0;
		while (done_items < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++) begin
					send_payload(counted);
					if (counted)
						done_items++;
				end
			end else if (pick < 70) begin
				len = 31'($urandom_range(0, 12));
				send_start(len);
				done_items++;
				for (k = 0; k < len; k++) begin
					send_payload(counted);
					done_items++;
				end
			end else if (pick < 90) begin
				case ($urandom_range(0, 2))
					0:       len = 31'($urandom_range(1, 12));
					1:       len = 31'($urandom_range(wsfb_pkg::LEN_DIRECT_MAX + 1,
						wsfb_pkg::LEN_16_LIMIT - 1));
					default: len = 31'($urandom_range(wsfb_pkg::LEN_16_LIMIT,
						32'h7fff_ffff));
				endcase
				send_start(len);
				done_items++;
				n = $urandom_range(0, 6);
				for (k = 0; k < n && k < len - 1; k++) begin
					send_payload(counted);
					done_items++;
				end
			end else begin
				n = $urandom_range(1, 3);
				for (k = 0; k < n; k++) begin
					send_start(31'd0);
					done_items++;
				end
			end
		end
	endtask

	initial begin : stimulus
		dir_row_t    row;
		logic        en;
		logic [31:0] key;
		int          ph;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = wsfb_pkg::CFG_MASK_ENABLE;
		cfg_data       = '0;
		in_valid       = 1'b0;
		req_type       = wsfb_pkg::REQ_START;
		frame_len      = '0;
		opcode         = '0;
		final_fragment = 1'b0;
		payload_byte   = '0;
		cur_typed      = 1'b0;
		cur_tn         = 0;
		cur_th         = '0;
		cur_tl         = 1'b0;

		// directed table; rows with a header written out are checked against it
		// stray byte after reset
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h55, 1, 0, '0, 0));
		// empty frame, length extremes, restart over open frames
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd0, 4'h1, 1'b1, 8'h00, 1, 2, 112'h8100, 1));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd125, 4'h2, 1'b0, 8'hff, 1, 2, 112'h027d, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd126, 4'hf, 1'b1, 8'h00, 1, 4, 112'h8f7e007e, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd65535, 4'h0, 1'b0, 8'hff, 1, 4, 112'h007effff, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd65536, 4'h8, 1'b1, 8'h00, 1, 10, 112'h887f0000000000010000, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'h7fffffff, 4'h9, 1'b1, 8'h00, 1, 10, 112'h897f000000007fffffff, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'h7fffffff, 4'hf, 1'b1, 8'hff, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd2, 4'hf, 1'b0, 8'h00, 1, 2, 112'h0f02, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h00, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'hff, 0, 0, '0, 0));
		// stray byte once the frame is complete
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd5, 4'h3, 1'b1, 8'ha5, 1, 0, '0, 0));
		// registers change while a frame is open
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd3, 4'h1, 1'b1, 8'h00, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h12, 0, 0, '0, 0));
		dir_rows.push_back(mk_cfg(wsfb_pkg::CFG_MASK_ENABLE, 32'd1));
		dir_rows.push_back(mk_cfg(wsfb_pkg::CFG_MASK_KEY, 32'hffff_ffff));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h34, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h56, 0, 0, '0, 0));
		// masked empty frame, then a masked payload over all key phases
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd0, 4'ha, 1'b1, 8'h00, 1, 6, 112'h8a80ffffffff, 1));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd5, 4'h2, 1'b1, 8'h00, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h00, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'hff, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h0f, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'hf0, 0, 0, '0, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'h81, 0, 0, '0, 0));
		// zero key is sent and applied as it is
		dir_rows.push_back(mk_cfg(wsfb_pkg::CFG_MASK_KEY, 32'd0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd1, 4'h1, 1'b1, 8'h00, 1, 6, 112'h818100000000, 0));
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_PAYLOAD,
			31'd0, 4'h0, 1'b0, 8'hc3, 0, 0, '0, 0));
		// longest header: 64-bit length with key
		dir_rows.push_back(mk_row(wsfb_pkg::REQ_START,
			31'd65536, 4'h2, 1'b0, 8'h00, 1, 14,
			112'h02ff0000000000010000_00000000, 0));

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// walk the directed table
		while (dir_rows.size() != 0) begin
			row = dir_rows.pop_front();
			if (row.is_cfg) begin
				write_reg(row.cfg_idx, row.cfg_val);
				settings_cnt++;
			end else begin
				push_item(row.kind, row.len, row.op, row.fin, row.pb, row.typed, row.tn,
					row.th, row.tl);
			end
		end

		// random phases, each under its own register setting
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
				0: begin
					en  = 1'b0;
					key = $urandom;
				end
				1, 4: begin
					en  = 1'b1;
					key = $urandom;
				end
				2: begin
					en  = 1'b1;
					key = 32'hffff_ffff;
				end
				3: begin
					en  = 1'b1;
					key = 32'd0;
				end
				default: begin
					en  = 1'b0;
					key = 32'd0;
				end
			endcase
			write_reg(wsfb_pkg::CFG_MASK_ENABLE, {31'd0, en});
			write_reg(wsfb_pkg::CFG_MASK_KEY, key);
			settings_cnt++;
			// long receiver hold-off while the sender keeps offering
			if (ph == 1)
				hold_asks++;
			run_random_phase(PHASE_ITEMS);
		end

		settle_idle();
		$display("covered %0d frame starts, %0d payload bytes and %0d dropped strays",
			start_cnt, pay_cnt, drop_cnt);
		$display("over %0d settings; checked %0d output bytes, %0d mismatches, %0d held",
			settings_cnt, checked_cnt, mismatch_cnt, full_cnt);
		if (mismatch_cnt == 0 && frame_bytes_exp.size() == 0)
			$display("tb_websocket_frame_builder: done, clean");
		else
			$display("tb_websocket_frame_builder: done, errors");
		$finish;
	end

endmodule
